// ===== sv/rsa_pkg.sv =====
`timescale 1ns / 1ps
package rsa_pkg;

  // Table geometry
  localparam int SLOTS       = 64;
  localparam int COUNT_BITS  = 16;
  localparam int SLOT_W      = $clog2(SLOTS);

  // Fixed field widths of the ports
  localparam int OP_W        = 2;
  localparam int IDX_W       = 6;
  localparam int LIMIT_W     = 7;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 16;

  // Compare widths wide enough for both operands
  localparam int ID_CMP_W  = (SLOT_W > IDX_W)   ? SLOT_W : IDX_W;
  localparam int LIM_CMP_W = (SLOT_W > LIMIT_W) ? SLOT_W : LIMIT_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

  typedef enum logic [OP_W-1:0] {
    OP_NEW = 2'd0,
    OP_GET = 2'd1,
    OP_REL = 2'd2,
    OP_BAD = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_INVALID     = 2'd2,
    ST_CREATE_FAIL = 2'd3
  } status_e;

  // Read-back of the addressed slot (zero from every other cell)
  typedef struct packed {
    logic                  used;
    logic [COUNT_BITS-1:0] count;
    logic                  flag;
  } rsa_rd_t;

  // Update broadcast to all cells
  typedef struct packed {
    logic                  we;       // write the target slot this cycle
    logic                  tgt_new;  // target is the claimed free slot, else the addressed one
    logic                  used;
    logic [COUNT_BITS-1:0] count;
    logic                  flag;
  } rsa_cmd_t;

endpackage

// ===== sv/refcounted_slot_allocator.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// command   in         start_i && !busy_o    opcode_i, slot_index_i, auto_free_i, create_ok_i
// result    out        done_o (one cycle)    status_o, granted_slot_o, count_after_o,
//                                            slot_freed_o
// config    in         slot_limit_we_i       slot_limit_i
//
// Each item is captured by the accept edge; in the execute state that follows it is applied to
// the cell row and the result is registered, shown for one cycle on done_o. busy_o is
// high for that one execute cycle. The execute path is the first-free ripple through
// the cell row plus one count increment/decrement. Reset frees all slots and sets
// the limit to 64; no clearing pass. The receiver cannot stall results.
module refcounted_slot_allocator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [rsa_pkg::OP_W-1:0]            opcode_i,
  input  logic [rsa_pkg::IDX_W-1:0]           slot_index_i,
  input  logic                                auto_free_i,
  input  logic                                create_ok_i,
  input  logic                                slot_limit_we_i,
  input  logic [rsa_pkg::LIMIT_W-1:0]         slot_limit_i,
  output logic                                done_o,
  output logic [rsa_pkg::STATUS_W-1:0]        status_o,
  output logic [rsa_pkg::IDX_W-1:0]           granted_slot_o,
  output logic [rsa_pkg::COUNT_OUT_W-1:0]     count_after_o,
  output logic                                slot_freed_o
);
  import rsa_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e               state_q;
  logic [LIMIT_W-1:0]   limit_q;
  logic [OP_W-1:0]      op_q;
  logic [IDX_W-1:0]     idx_q;
  logic                 af_q;
  logic                 ok_q;

  logic [SLOTS:0]       found;
  logic [SLOTS-1:0]     take;
  rsa_rd_t              rd_v [SLOTS];
  rsa_rd_t              rd;
  logic [SLOT_W-1:0]    grant;
  rsa_cmd_t             cmd;

  status_e                 res_status;
  logic [IDX_W-1:0]        res_slot;
  logic [COUNT_BITS-1:0]   res_count;
  logic                    res_freed;
  logic [COUNT_OUT_W-1:0]  res_count_sat;

  assign busy_o   = (state_q == S_EXEC);
  assign found[0] = 1'b0;

  // Row of slot cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    rsa_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cell_id_i    (SLOT_W'(i)),
      .slot_limit_i (limit_q),
      .idx_i        (idx_q),
      .found_i      (found[i]),
      .found_o      (found[i+1]),
      .take_o       (take[i]),
      .rd_o         (rd_v[i]),
      .cmd_i        (cmd)
    );
  end

  // Collect the addressed slot and encode the claimed one
  always_comb begin
    rd    = '0;
    grant = '0;
    for (int i = 0; i < SLOTS; i++) begin
      rd    = rsa_rd_t'(rd | rd_v[i]);
      grant = grant | (take[i] ? SLOT_W'(i) : '0);
    end
  end

  // Decode the operation into a cell update and a result
  always_comb begin
    logic [COUNT_BITS-1:0] dec;
    dec         = (rd.count == '0) ? '0 : rd.count - COUNT_BITS'(1);
    cmd         = '0;
    res_status  = ST_INVALID;
    res_slot    = '0;
    res_count   = '0;
    res_freed   = 1'b0;
    unique case (opcode_e'(op_q))
      OP_NEW: begin
        if (!found[SLOTS]) begin
          res_status = ST_FULL;
        end else if (!ok_q) begin
          res_status = ST_CREATE_FAIL;
        end else begin
          cmd.we      = busy_o;
          cmd.tgt_new = 1'b1;
          cmd.used    = 1'b1;
          cmd.count   = COUNT_BITS'(1);
          cmd.flag    = af_q;
          res_status  = ST_OK;
          res_slot    = IDX_W'(grant);
          res_count   = COUNT_BITS'(1);
        end
      end
      OP_GET: begin
        if (rd.used) begin
          cmd.we     = busy_o;
          cmd.used   = 1'b1;
          cmd.count  = (rd.count == '1) ? rd.count : rd.count + COUNT_BITS'(1);
          cmd.flag   = rd.flag;
          res_status = ST_OK;
          res_slot   = idx_q;
          res_count  = cmd.count;
        end
      end
      OP_REL: begin
        if (rd.used) begin
          cmd.we     = busy_o;
          res_status = ST_OK;
          res_slot   = idx_q;
          if (dec == '0 && rd.flag) begin
            res_freed = 1'b1;
          end else begin
            cmd.used  = 1'b1;
            cmd.count = dec;
            cmd.flag  = rd.flag;
            res_count = dec;
          end
        end
      end
      OP_BAD: begin
        res_status = ST_INVALID;
      end
      default: begin
        res_status = ST_INVALID;
      end
    endcase
  end

  assign res_count_sat = (|(res_count >> COUNT_OUT_W)) ? '1 : COUNT_OUT_W'(res_count);

  // Slot limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (slot_limit_we_i) begin
      limit_q <= slot_limit_i;
    end
  end

  // Captured command
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      op_q  <= opcode_i;
      idx_q <= slot_index_i;
      af_q  <= auto_free_i;
      ok_q  <= create_ok_i;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      done_o         <= 1'b0;
      status_o       <= '0;
      granted_slot_o <= '0;
      count_after_o  <= '0;
      slot_freed_o   <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q        <= S_IDLE;
          done_o         <= 1'b1;
          status_o       <= res_status;
          granted_slot_o <= res_slot;
          count_after_o  <= res_count_sat;
          slot_freed_o   <= res_freed;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Every accepted item yields its result on done_o
  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 done_o)
    else $error("result missing after accepted item");

  // At most one cell claims a free slot
  a_take_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(take))
    else $error("several cells claimed a slot");

  // Failed results carry no slot and no count
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (granted_slot_o == '0 && count_after_o == '0))
    else $error("failed result carries payload");

  // A freed slot reports count zero on an ok release
  a_freed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && slot_freed_o) |-> (status_o == ST_OK && count_after_o == '0))
    else $error("freed slot with nonzero count");

  // Cells are only written during the execute cycle
  a_we_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.we |-> busy_o)
    else $error("cell write outside execute");
`endif

endmodule

// ===== sv/rsa_cell.sv =====
`timescale 1ns / 1ps
module rsa_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [rsa_pkg::SLOT_W-1:0]        cell_id_i,
  input  logic [rsa_pkg::LIMIT_W-1:0]       slot_limit_i,
  input  logic [rsa_pkg::IDX_W-1:0]         idx_i,
  input  logic                              found_i,
  output logic                              found_o,
  output logic                              take_o,
  output rsa_pkg::rsa_rd_t                  rd_o,
  input  rsa_pkg::rsa_cmd_t                 cmd_i
);
  import rsa_pkg::*;

  logic                  used_q;
  logic [COUNT_BITS-1:0] count_q;
  logic                  flag_q;
  logic                  sel;
  logic                  free;
  logic                  hit;

  // Addressed by index, or free and inside the search limit
  assign sel  = (ID_CMP_W'(cell_id_i) == ID_CMP_W'(idx_i));
  assign free = !used_q && (LIM_CMP_W'(cell_id_i) < LIM_CMP_W'(slot_limit_i));

  // First-free ripple: claim only if no lower cell was free
  assign take_o  = free && !found_i;
  assign found_o = found_i || free;

  assign rd_o.used  = sel && used_q;
  assign rd_o.count = sel ? count_q : '0;
  assign rd_o.flag  = sel && flag_q;

  assign hit = cmd_i.we && (cmd_i.tgt_new ? take_o : sel);

  // In-use mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else if (hit) begin
      used_q <= cmd_i.used;
    end
  end

  // Count and auto-free flag, only meaningful while used
  always_ff @(posedge clk_i) begin
    if (hit) begin
      count_q <= cmd_i.count;
      flag_q  <= cmd_i.flag;
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import rsa_pkg::*;

  // Tracks the slot table and the grants it should produce
  class slot_grant_tracker;
    typedef struct packed {
      status_e               status;
      logic [IDX_W-1:0]      slot;
      logic [COUNT_OUT_W-1:0] count;
      logic                  freed;
    } grant_t;

    grant_t                expected_grants[$];
    bit                    used [SLOTS];
    logic [COUNT_BITS-1:0] count [SLOTS];
    bit                    auto_rel [SLOTS];
    logic [LIMIT_W-1:0]    limit;
    int                    errors;

    function new();
      limit  = LIMIT_RESET;
      errors = 0;
      foreach (used[i]) begin
        used[i]     = 1'b0;
        count[i]    = '0;
        auto_rel[i] = 1'b0;
      end
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      limit = value;
    endfunction

    function int pending();
      return expected_grants.size();
    endfunction

    // Apply one accepted command to the table and queue its grant
    function void note_request(opcode_e op, logic [IDX_W-1:0] idx, logic af, logic ok);
      grant_t g;
      int     lim;
      int     pick;
      g    = '{status: ST_INVALID, slot: '0, count: '0, freed: 1'b0};
      lim  = (int'(limit) < SLOTS) ? int'(limit) : SLOTS;
      pick = -1;
      if (op == OP_NEW) begin
        for (int i = 0; i < lim; i++) begin
          if (!used[i] && pick < 0) pick = i;
        end
        if (pick < 0) begin
          g.status = ST_FULL;
        end else if (!ok) begin
          // creation failed: slot stays free
          g.status = ST_CREATE_FAIL;
        end else begin
          used[pick]     = 1'b1;
          count[pick]    = COUNT_BITS'(1);
          auto_rel[pick] = af;
          g = '{status: ST_OK, slot: IDX_W'(pick), count: COUNT_OUT_W'(1), freed: 1'b0};
        end
      end else if (op == OP_BAD || int'(idx) >= SLOTS || !used[idx]) begin
        g.status = ST_INVALID;
      end else if (op == OP_GET) begin
        if (count[idx] != {COUNT_BITS{1'b1}}) count[idx] = count[idx] + 1'b1;
        g = '{status: ST_OK, slot: idx, count: COUNT_OUT_W'(count[idx]), freed: 1'b0};
      end else begin
        if (count[idx] != 0) count[idx] = count[idx] - 1'b1;
        if (count[idx] == 0 && auto_rel[idx]) begin
          used[idx]     = 1'b0;
          auto_rel[idx] = 1'b0;
          g = '{status: ST_OK, slot: idx, count: '0, freed: 1'b1};
        end else begin
          g = '{status: ST_OK, slot: idx, count: COUNT_OUT_W'(count[idx]), freed: 1'b0};
        end
      end
      expected_grants.push_back(g);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [IDX_W-1:0] slot,
                               logic [COUNT_OUT_W-1:0] cnt, logic freed);
      grant_t g;
      if (expected_grants.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: status %0d slot %0d count %0d freed %0d",
                 $time, st, slot, cnt, freed);
      end else begin
        g = expected_grants.pop_front();
        compare_field("status", g.status, st);
        compare_field("granted_slot", g.slot, slot);
        compare_field("count_after", g.count, cnt);
        compare_field("slot_freed", g.freed, freed);
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 500;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  logic [OP_W-1:0]        opcode_i = '0;
  logic [IDX_W-1:0]       slot_index_i = '0;
  logic                   auto_free_i = 1'b0;
  logic                   create_ok_i = 1'b0;
  logic                   slot_limit_we_i = 1'b0;
  logic [LIMIT_W-1:0]     slot_limit_i = '0;
  logic                   done_o;
  logic [STATUS_W-1:0]    status_o;
  logic [IDX_W-1:0]       granted_slot_o;
  logic [COUNT_OUT_W-1:0] count_after_o;
  logic                   slot_freed_o;

  slot_grant_tracker tracker;
  bit                burst = 1'b0;
  int                quiet_cycles = 0;

  refcounted_slot_allocator u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .slot_index_i   (slot_index_i),
    .auto_free_i    (auto_free_i),
    .create_ok_i    (create_ok_i),
    .slot_limit_we_i(slot_limit_we_i),
    .slot_limit_i   (slot_limit_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .granted_slot_o (granted_slot_o),
    .count_after_o  (count_after_o),
    .slot_freed_o   (slot_freed_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      tracker.check_result(status_o, granted_slot_o, count_after_o, slot_freed_o);
    end
  end

  // Watchdog: cycles with no accepted command and no result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Gap after an item; bursts of back-to-back items now and then
  function automatic int draw_gap();
    if ($urandom_range(0, 23) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, 16);
  endfunction

  // Random slot that is in use, or any slot if none is
  function automatic logic [IDX_W-1:0] pick_used_slot();
    int live[$];
    foreach (tracker.used[i]) begin
      if (tracker.used[i]) live.push_back(i);
    end
    if (live.size() == 0) return IDX_W'($urandom_range(0, SLOTS - 1));
    return IDX_W'(live[$urandom_range(0, live.size() - 1)]);
  endfunction

  // Present one command, hold until accepted, then idle for a random gap
  task automatic send_item(opcode_e op, logic [IDX_W-1:0] idx, logic af, logic ok);
    int gap;
    start_i      <= 1'b1;
    opcode_i     <= op;
    slot_index_i <= idx;
    auto_free_i  <= af;
    create_ok_i  <= ok;
    do @(posedge clk_i); while (!(start_i && !busy_o));
    tracker.note_request(op, idx, af, ok);
    gap = draw_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait for every outstanding grant
  task automatic drain();
    start_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    drain();
    slot_limit_we_i <= 1'b1;
    slot_limit_i    <= value;
    @(posedge clk_i);
    slot_limit_we_i <= 1'b0;
    tracker.set_limit(value);
    @(posedge clk_i);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      send_item(OP_NEW, IDX_W'($urandom), 1'($urandom), ($urandom_range(0, 9) != 0));
    end else if (r < 60) begin
      send_item(OP_GET, pick_used_slot(), 1'($urandom), 1'($urandom));
    end else if (r < 92) begin
      send_item(OP_REL, pick_used_slot(), 1'($urandom), 1'($urandom));
    end else if (r < 97) begin
      send_item(opcode_e'($urandom_range(1, 2)), IDX_W'($urandom), 1'($urandom),
                1'($urandom));
    end else begin
      send_item(OP_BAD, IDX_W'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    logic [LIMIT_W-1:0] phase_limits [8];
    tracker = new();
    phase_limits = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd8, 7'd2, 7'd64, 7'd64};
    phase_limits[7] = LIMIT_W'($urandom_range(1, 127));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unused ids, unknown opcode, allocation, create failure
    send_item(OP_REL, 6'd0, 1'b0, 1'b1);
    send_item(OP_GET, 6'd63, 1'b1, 1'b1);
    send_item(OP_BAD, 6'd0, 1'b0, 1'b0);
    send_item(OP_NEW, 6'd63, 1'b1, 1'b1);
    send_item(OP_NEW, 6'd0, 1'b0, 1'b1);
    send_item(OP_NEW, 6'd0, 1'b1, 1'b0);
    send_item(OP_NEW, 6'd21, 1'b0, 1'b1);
    // count up/down, auto release, release at zero on a kept slot
    send_item(OP_GET, 6'd0, 1'b0, 1'b0);
    send_item(OP_REL, 6'd0, 1'b0, 1'b0);
    send_item(OP_REL, 6'd0, 1'b0, 1'b0);
    send_item(OP_REL, 6'd1, 1'b0, 1'b0);
    send_item(OP_REL, 6'd1, 1'b0, 1'b0);
    send_item(OP_GET, 6'd1, 1'b0, 1'b0);
    send_item(OP_BAD, 6'd1, 1'b1, 1'b1);
    send_item(OP_GET, 6'd0, 1'b0, 1'b0);

    // Zero limit: nothing can be allocated
    write_limit(7'd0);
    send_item(OP_NEW, 6'd0, 1'b0, 1'b1);
    // Lowered limit: full below it, slots above it still addressable
    write_limit(7'd2);
    send_item(OP_NEW, 6'd0, 1'b0, 1'b1);
    send_item(OP_NEW, 6'd0, 1'b0, 1'b1);
    send_item(OP_GET, 6'd2, 1'b0, 1'b0);
    send_item(OP_REL, 6'd2, 1'b0, 1'b0);
    // Limit above the table saturates
    write_limit(7'd127);
    send_item(OP_NEW, 6'd42, 1'b1, 1'b0);
    send_item(OP_NEW, 6'd63, 1'b1, 1'b1);
    write_limit(7'd1);
    send_item(OP_NEW, 6'd0, 1'b1, 1'b1);

    // Back-to-back increments on the kept slot 1
    drain();
    burst = 1'b1;
    for (int n = 0; n < 32; n++) begin
      start_i      <= 1'b1;
      opcode_i     <= OP_GET;
      slot_index_i <= 6'd1;
      do @(posedge clk_i); while (!(start_i && !busy_o));
      tracker.note_request(OP_GET, 6'd1, auto_free_i, create_ok_i);
    end
    burst = 1'b0;
    send_item(OP_REL, 6'd1, 1'b0, 1'b0);

    // Random phases over several limits
    foreach (phase_limits[p]) begin
      write_limit(phase_limits[p]);
      repeat (210) random_item();
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      if (tracker.pending() != 0)
        $display("%0t: %0d expected results never arrived", $time, tracker.pending());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
